// ===== rtl/ffa_pkg.sv =====
package ffa_pkg;

  localparam int MEM_BYTES   = 128;
  localparam int MAX_HANDLES = 128;
  localparam int ADDR_W      = $clog2(MEM_BYTES);
  localparam int HND_W       = $clog2(MAX_HANDLES);
  localparam int FILL_W      = 16;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] status_t;
  typedef logic [7:0] byte_t;

  localparam cmd_t CMD_ALLOC  = 2'd0;
  localparam cmd_t CMD_ERASE  = 2'd1;
  localparam cmd_t CMD_DEFRAG = 2'd2;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_NULL    = 2'd1;
  localparam status_t ST_ILLEGAL = 2'd2;

endpackage

// ===== rtl/first_fit_allocator_defrag.sv =====
// Alloc: first-fit byte scan up to mem_size (at most MEM_BYTES), then a table write.
// Erase: a block table read through the read port, then a clear. Defragment: (live
// blocks + 1) passes over the block table, one entry read per cycle, each but the last
// moving one block. Results (alloc, failed erase) wait until the output register is free.
// Reset (rst, synchronous) clears the occupancy map, live flags, handle counter and
// sets mem_size to 128; the block table holds garbage until written.
module first_fit_allocator_defrag (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  ffa_pkg::byte_t   cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  ffa_pkg::cmd_t    command,
  input  ffa_pkg::byte_t   alloc_size,
  input  ffa_pkg::byte_t   handle,
  output logic             out_valid,
  input  logic             out_stall,
  output ffa_pkg::status_t status,
  output ffa_pkg::byte_t   new_handle
);
  import ffa_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ASCAN = 4'd1;
  localparam logic [3:0] S_ADONE = 4'd2;
  localparam logic [3:0] S_ECLR  = 4'd3;
  localparam logic [3:0] S_DSCAN = 4'd4;
  localparam logic [3:0] S_DMOVE = 4'd5;
  localparam logic [3:0] S_RESP  = 4'd6;

  localparam int KEY_W = ADDR_W + HND_W;
  localparam logic [HND_W:0] IDX_END = (HND_W + 1)'(MAX_HANDLES);

  // Set bits [start, start+len) of a byte map
  function automatic logic [MEM_BYTES-1:0] run_mask(input logic [FILL_W-1:0] start,
                                                    input logic [FILL_W-1:0] len);
    logic [FILL_W:0] stop;
    logic [MEM_BYTES-1:0] m;
    stop = {1'b0, start} + {1'b0, len};
    for (int a = 0; a < MEM_BYTES; a++) begin
      m[a] = ((FILL_W + 1)'(a) >= {1'b0, start}) && ((FILL_W + 1)'(a) < stop);
    end
    return m;
  endfunction

  logic [3:0]           state;
  logic [MEM_BYTES-1:0] occ;
  logic [MAX_HANDLES-1:0] live;
  byte_t                next_handle;
  byte_t                mem_size;
  byte_t                size_q;
  logic [HND_W-1:0]     eidx;
  byte_t                scan_a;
  byte_t                run_len;
  logic [ADDR_W-1:0]    run_start;
  logic [ADDR_W-1:0]    found_start;
  logic [HND_W:0]       idx;
  logic                 p_vld;
  logic                 p_live;
  logic [HND_W-1:0]     p_h;
  logic                 have_last;
  logic [KEY_W-1:0]     last_key;
  logic                 have_best;
  logic [KEY_W-1:0]     best_key;
  byte_t                best_len;
  logic [FILL_W-1:0]    fill;
  status_t              res_status;
  byte_t                res_handle;

  // Block table
  logic [ADDR_W-1:0] block_start  [MAX_HANDLES];
  byte_t             block_length [MAX_HANDLES];
  logic [ADDR_W-1:0] rd_start;
  byte_t             rd_len;
  logic [HND_W-1:0]  mem_raddr;
  logic [HND_W-1:0]  mem_waddr;
  logic              we_start;
  logic              we_len;
  logic [ADDR_W-1:0] wdata_start;

  byte_t             lim;
  logic [HND_W-1:0]  hidx;
  logic              erase_bad;
  logic [KEY_W-1:0]  cur_key;
  logic              take_best;
  logic [ADDR_W-1:0] fill_clamp;
  byte_t             run_len_next;
  logic [ADDR_W-1:0] run_start_next;
  logic              out_free;
  logic              in_acc;

  assign lim       = (mem_size > byte_t'(MEM_BYTES)) ? byte_t'(MEM_BYTES) : mem_size;
  assign hidx      = HND_W'(handle - 8'd1);
  assign erase_bad = (handle == '0) || (handle > next_handle) || !live[hidx];
  assign cur_key   = {rd_start, p_h};
  assign take_best = p_vld && p_live && (!have_last || cur_key > last_key)
                     && (!have_best || cur_key < best_key);
  assign fill_clamp = (fill < FILL_W'(MEM_BYTES)) ? fill[ADDR_W-1:0]
                                                   : ADDR_W'(MEM_BYTES - 1);
  assign run_len_next   = run_len + 8'd1;
  assign run_start_next = (run_len == '0) ? scan_a[ADDR_W-1:0] : run_start;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Table port control
  always_comb begin
    mem_raddr   = (state == S_IDLE) ? hidx : idx[HND_W-1:0];
    mem_waddr   = next_handle[HND_W-1:0];
    we_start    = 1'b0;
    we_len      = 1'b0;
    wdata_start = found_start;
    if (state == S_ADONE) begin
      we_start = 1'b1;
      we_len   = 1'b1;
    end else if (state == S_DMOVE && have_best) begin
      mem_waddr   = best_key[HND_W-1:0];
      we_start    = 1'b1;
      wdata_start = fill_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (we_start) block_start[mem_waddr] <= wdata_start;
    if (we_len) block_length[mem_waddr] <= size_q;
    rd_start <= block_start[mem_raddr];
    rd_len   <= block_length[mem_raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      occ         <= '0;
      live        <= '0;
      next_handle <= '0;
      mem_size    <= byte_t'(MEM_BYTES);
      out_valid   <= 1'b0;
      p_vld       <= 1'b0;
      have_last   <= 1'b0;
      have_best   <= 1'b0;
    end else begin
      if (cfg_we) mem_size <= cfg_data;
      if (out_valid && !out_stall && state != S_RESP) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            size_q <= alloc_size;
            eidx   <= hidx;
            case (command)
              CMD_ALLOC: begin
                if (next_handle >= byte_t'(MAX_HANDLES) || lim == '0 || alloc_size > lim) begin
                  res_status <= ST_NULL;
                  res_handle <= '0;
                  state      <= S_RESP;
                end else if (alloc_size == '0) begin
                  found_start <= '0;
                  state       <= S_ADONE;
                end else begin
                  scan_a  <= '0;
                  run_len <= '0;
                  state   <= S_ASCAN;
                end
              end
              CMD_ERASE: begin
                if (erase_bad) begin
                  res_status <= ST_ILLEGAL;
                  res_handle <= '0;
                  state      <= S_RESP;
                end else begin
                  state <= S_ECLR;
                end
              end
              CMD_DEFRAG: begin
                idx       <= '0;
                p_vld     <= 1'b0;
                have_last <= 1'b0;
                have_best <= 1'b0;
                fill      <= '0;
                state     <= S_DSCAN;
              end
              default: ;
            endcase
          end
        end
        S_ASCAN: begin
          // Walk one byte, track the current free run
          if (scan_a == lim) begin
            res_status <= ST_NULL;
            res_handle <= '0;
            state      <= S_RESP;
          end else begin
            scan_a <= scan_a + 8'd1;
            if (occ[scan_a[ADDR_W-1:0]]) begin
              run_len <= '0;
            end else begin
              run_len   <= run_len_next;
              run_start <= run_start_next;
              if (run_len_next == size_q) begin
                found_start <= run_start_next;
                state       <= S_ADONE;
              end
            end
          end
        end
        S_ADONE: begin
          live[next_handle[HND_W-1:0]] <= 1'b1;
          occ         <= occ | run_mask(FILL_W'(found_start), FILL_W'(size_q));
          next_handle <= next_handle + 8'd1;
          res_status  <= ST_OK;
          res_handle  <= next_handle + 8'd1;
          state       <= S_RESP;
        end
        S_ECLR: begin
          live[eidx] <= 1'b0;
          occ        <= occ & ~run_mask(FILL_W'(rd_start), FILL_W'(rd_len));
          state      <= S_IDLE;
        end
        S_DSCAN: begin
          // Issue one table read per cycle, pick the smallest key above the last one
          p_vld  <= (idx != IDX_END);
          p_live <= live[idx[HND_W-1:0]];
          p_h    <= idx[HND_W-1:0];
          if (idx != IDX_END) idx <= idx + (HND_W + 1)'(1);
          if (take_best) begin
            have_best <= 1'b1;
            best_key  <= cur_key;
            best_len  <= rd_len;
          end
          if (idx == IDX_END && !p_vld) state <= S_DMOVE;
        end
        S_DMOVE: begin
          if (have_best) begin
            fill      <= fill + FILL_W'(best_len);
            last_key  <= best_key;
            have_last <= 1'b1;
            have_best <= 1'b0;
            idx       <= '0;
            state     <= S_DSCAN;
          end else begin
            occ   <= run_mask('0, fill);
            state <= S_IDLE;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            status     <= res_status;
            new_handle <= res_handle;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_handle_cap: assert property (@(posedge clk) disable iff (rst)
    next_handle <= byte_t'(MAX_HANDLES))
    else $error("handle counter overran");

  a_live_count: assert property (@(posedge clk) disable iff (rst)
    $countones(live) <= 32'(next_handle))
    else $error("more live blocks than handles given");

  a_ok_handle: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> new_handle != '0)
    else $error("alloc beat carries null handle");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> new_handle == '0)
    else $error("failure beat carries a handle");

  a_erase_clears: assert property (@(posedge clk) disable iff (rst)
    state == S_ECLR |=> !live[$past(eidx)])
    else $error("erased handle still live");
`endif

endmodule

// ===== test/tb_first_fit_allocator_defrag.sv =====
`timescale 1ns / 100ps

import ffa_pkg::*;

// Holds the allocator's expected state and the queue of pending responses
class alloc_scoreboard;
  bit      used_map  [MEM_BYTES];
  int      blk_base  [MAX_HANDLES];
  int      blk_len   [MAX_HANDLES];
  bit      blk_alive [MAX_HANDLES];
  int      issued;
  int      mem_limit;
  status_t want_status[$];
  byte_t   want_handle[$];
  int      errors;

  function void clear_state();
    foreach (used_map[i]) used_map[i] = 0;
    foreach (blk_alive[i]) blk_alive[i] = 0;
    issued = 0;
    mem_limit = 128;
  endfunction

  function void set_mem(byte_t v);
    mem_limit = v;
  endfunction

  function int live_count();
    int n;
    n = 0;
    foreach (blk_alive[i]) n += blk_alive[i];
    return n;
  endfunction

  function bit is_live(int h);
    return h >= 1 && h <= issued && h <= MAX_HANDLES && blk_alive[h-1];
  endfunction

  // Apply one accepted command and queue its response, if any
  function void note_command(cmd_t cmd, byte_t sz, byte_t h);
    int lim, fill;
    bit fits;
    if (cmd == CMD_ALLOC) begin
      lim = mem_limit > MEM_BYTES ? MEM_BYTES : mem_limit;
      if (issued < MAX_HANDLES) begin
        for (int j = 0; j < lim && j + sz <= lim; j++) begin
          fits = 1;
          for (int a = j; a < j + sz; a++)
            if (used_map[a]) fits = 0;
          if (fits) begin
            blk_base[issued] = j;
            blk_len[issued] = sz;
            blk_alive[issued] = 1;
            issued++;
            for (int a = j; a < j + sz && a < MEM_BYTES; a++) used_map[a] = 1;
            want_status.push_back(ST_OK);
            want_handle.push_back(byte_t'(issued));
            return;
          end
        end
      end
      want_status.push_back(ST_NULL);
      want_handle.push_back(0);
    end else if (cmd == CMD_ERASE) begin
      if (!is_live(h)) begin
        want_status.push_back(ST_ILLEGAL);
        want_handle.push_back(0);
      end else begin
        blk_alive[h-1] = 0;
        for (int a = blk_base[h-1]; a < blk_base[h-1] + blk_len[h-1] && a < MEM_BYTES; a++)
          used_map[a] = 0;
      end
    end else if (cmd == CMD_DEFRAG) begin
      fill = 0;
      for (int a = 0; a < MEM_BYTES; a++)
        for (int k = 0; k < MAX_HANDLES; k++)
          if (blk_alive[k] && blk_base[k] == a) begin
            blk_base[k] = fill < MEM_BYTES ? fill : MEM_BYTES - 1;
            fill += blk_len[k];
          end
      foreach (used_map[i]) used_map[i] = i < fill;
    end
  endfunction

  function void report(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endfunction

  // Compare one response beat with the oldest expectation
  function void check_response(status_t st, byte_t nh);
    status_t es;
    byte_t eh;
    if (want_status.size() == 0) begin
      report($sformatf("unexpected response status=%0d handle=%0d", st, nh));
      return;
    end
    es = want_status.pop_front();
    eh = want_handle.pop_front();
    if (st !== es) report($sformatf("status got %0d want %0d", st, es));
    if (nh !== eh) report($sformatf("new_handle got %0d want %0d", nh, eh));
  endfunction
endclass

module tb_first_fit_allocator_defrag;
  // Command code that the block ignores
  localparam cmd_t CMD_UNUSED = 2'd3;

  logic    clk;
  logic    rst;
  logic    cfg_we;
  byte_t   cfg_data;
  logic    in_valid;
  logic    in_stall;
  cmd_t    command;
  byte_t   alloc_size;
  byte_t   handle;
  logic    out_valid;
  logic    out_stall;
  status_t status;
  byte_t   new_handle;
  bit      stall_on;

  alloc_scoreboard sb;

  first_fit_allocator_defrag DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .alloc_size(alloc_size), .handle(handle), .out_valid(out_valid),
    .out_stall(out_stall), .status(status), .new_handle(new_handle)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Send one command beat and wait for it to be taken; valid stays up for a back-to-back beat
  task send_beat(cmd_t c, byte_t s, byte_t h);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    command <= c;
    alloc_size <= s;
    handle <= h;
    do @(posedge clk); while (in_stall);
    sb.note_command(c, s, h);
  endtask

  // Drop valid, wait for all responses, then let any erase or defrag finish
  task drain();
    in_valid <= 0;
    while (sb.want_status.size() != 0) @(posedge clk);
    repeat (20000) @(posedge clk);
  endtask

  task write_mem(byte_t v);
    drain();
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_mem(v);
  endtask

  // Receive side: random stalls, check each beat
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_response(status, new_handle);
  end

  initial begin
    int g;
    stall_on = 0;
    forever begin
      @(posedge clk);
      if (stall_on) begin
        g = gap_len();
        if (g > 0) begin
          out_stall <= 1;
          repeat (g) @(posedge clk);
        end
        out_stall <= 0;
        g = $urandom_range(0, 5);
        repeat (g) @(posedge clk);
      end else begin
        out_stall <= 0;
      end
    end
  end

  // Random command with mostly well-formed handles
  task random_beat();
    int r;
    byte_t s, h;
    r = $urandom_range(0, 99);
    s = ($urandom_range(0, 9) == 0) ? byte_t'($urandom) : byte_t'($urandom_range(1, 24));
    if ($urandom_range(0, 9) < 8 && sb.issued > 0)
      h = byte_t'($urandom_range(1, sb.issued));
    else
      h = byte_t'($urandom);
    if (r < 55) send_beat(CMD_ALLOC, s, h);
    else if (r < 88) send_beat(CMD_ERASE, s, h);
    else if (r < 96) send_beat(CMD_DEFRAG, s, h);
    else send_beat(CMD_UNUSED, s, h);
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    sb.errors = 0;
    rst = 1;
    cfg_we = 0;
    cfg_data = 0;
    in_valid = 0;
    command = CMD_ALLOC;
    alloc_size = 0;
    handle = 0;
    out_stall = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, every command, special cases
    send_beat(CMD_ALLOC, 8'd0, 8'd0);
    send_beat(CMD_ALLOC, 8'd128, 8'd0);
    send_beat(CMD_ALLOC, 8'd1, 8'd0);
    send_beat(CMD_ERASE, 8'd0, 8'd0);
    send_beat(CMD_ERASE, 8'd0, 8'd255);
    send_beat(CMD_ERASE, 8'd0, 8'd2);
    send_beat(CMD_ERASE, 8'd0, 8'd2);
    send_beat(CMD_ALLOC, 8'd255, 8'hff);
    send_beat(CMD_ALLOC, 8'd10, 8'd0);
    send_beat(CMD_ALLOC, 8'd5, 8'd0);
    send_beat(CMD_ERASE, 8'd0, 8'd4);
    send_beat(CMD_DEFRAG, 8'hff, 8'hff);
    send_beat(CMD_UNUSED, 8'hff, 8'hff);
    send_beat(CMD_ALLOC, 8'd113, 8'd0);
    write_mem(8'd0);
    send_beat(CMD_ALLOC, 8'd1, 8'd0);
    send_beat(CMD_ALLOC, 8'd0, 8'd0);
    write_mem(8'd255);
    send_beat(CMD_ALLOC, 8'd1, 8'd0);
    write_mem(8'd20);
    send_beat(CMD_ALLOC, 8'd4, 8'd0);
    send_beat(CMD_DEFRAG, 8'd0, 8'd0);
    write_mem(8'd1);
    send_beat(CMD_ALLOC, 8'd1, 8'd0);

    // Random phases over several memory sizes, with erase churn
    stall_on = 1;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_mem(8'd128);
        1: write_mem(8'd40);
        2: write_mem(8'd1);
        3: write_mem(byte_t'($urandom_range(2, 127)));
        default: write_mem(8'd128);
      endcase
      for (int i = 0; i < 100; i++) begin
        random_beat();
        if (i == 50) begin
          in_valid <= 0;
          while (sb.want_status.size() != 0) @(posedge clk);
        end
      end
    end
    // Handles are exhausted by now or soon; push allocs past the limit
    for (int i = 0; i < 30 && sb.issued < MAX_HANDLES; i++) send_beat(CMD_ALLOC, 8'd0, 8'd0);
    send_beat(CMD_ALLOC, 8'd0, 8'd0);
    send_beat(CMD_ERASE, 8'd0, 8'd200);

    drain();
    if (sb.errors == 0) begin
      $display("tb_first_fit_allocator_defrag OK");
    end else begin
      $display("tb_first_fit_allocator_defrag NOT OK");
    end
    $finish;
  end

  initial begin
    #1s;
    $display("tb_first_fit_allocator_defrag NOT OK");
    $finish;
  end
endmodule
